// File: rtl/osa_pkg.sv
// Shared types and constants for the order-split page allocator.
// Used by order_split_page_allocator; depends on nothing.
package osa_pkg;

  // Fixed widths of the item fields
  localparam int PAGE_W = 16;
  localparam int CNT_W  = 17;
  localparam int ORD_W  = 6;   // holds any order index up to 63
  localparam int BL_W   = 5;   // bit length of a count field

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_DESC = 2'd2,
    ST_ZERO = 2'd3
  } status_t;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Number of significant bits in a count (0 for zero)
  function automatic logic [BL_W-1:0] bit_len(input logic [CNT_W-1:0] v);
    logic [BL_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) r = BL_W'(i + 1);
    end
    return r;
  endfunction

endpackage

// File: rtl/order_split_page_allocator.sv
// Page allocator with one LIFO free list per power-of-two order, no merging.
// Steps: accept, scan the orders, split (pop, take two descriptors, recycle),
// pop, one piece per take along the run, end the run, recycle the popped
// descriptor and register the result; a take reads the recycle list if it can.
// One item at a time, through the single RAM port pair.
// Reset (synchronous, rst_n low) empties all lists and clears the fault;
// the descriptor RAM needs no clearing.
// Depends on osa_pkg and osa_ram.
module order_split_page_allocator #(
  parameter int ORDER_COUNT      = 17,
  parameter int DESCRIPTOR_DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [osa_pkg::CNT_W-1:0]  in_page_count,
  input  logic [osa_pkg::PAGE_W-1:0] in_start_page,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [osa_pkg::PAGE_W-1:0] out_alloc_start,
  output logic [1:0]                 out_status
);
  import osa_pkg::*;

  localparam int DW  = $clog2(DESCRIPTOR_DEPTH + 1);
  localparam int AW  = $clog2(DESCRIPTOR_DEPTH);
  localparam int OIW = $clog2(ORDER_COUNT);
  localparam int MW  = PAGE_W + DW;
  localparam logic [DW-1:0] NULL_D = DW'(DESCRIPTOR_DEPTH);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SCAN   = 14'b00000000000010,
    S_SPL_RD = 14'b00000000000100,
    S_SPL_WT = 14'b00000000001000,
    S_SPL_HI = 14'b00000000010000,
    S_SPL_RC = 14'b00000000100000,
    S_POP_RD = 14'b00000001000000,
    S_POP_WT = 14'b00000010000000,
    S_RUN    = 14'b00000100000000,
    S_FREC   = 14'b00001000000000,
    S_TAKE   = 14'b00010000000000,
    S_TAKEW  = 14'b00100000000000,
    S_PWR    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t              state_r, state_nxt, ret_r, ret_nxt;
  logic                alloc_r, alloc_nxt;
  logic [CNT_W-1:0]    req_cnt_r, req_cnt_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PAGE_W-1:0]   run_start_r, run_start_nxt;
  logic [ORD_W-1:0]    ord_r, ord_nxt;
  logic [ORD_W-1:0]    k_r, k_nxt;
  logic [PAGE_W-1:0]   blk_r, blk_nxt;
  logic [DW-1:0]       sd_r, sd_nxt;
  logic [DW-1:0]       pd_r, pd_nxt;
  logic [PAGE_W-1:0]   pstart_r, pstart_nxt;
  logic [ORD_W-1:0]    pord_r, pord_nxt;
  logic [DW-1:0]       recycle_r, recycle_nxt;
  logic [DW-1:0]       unused_r, unused_nxt;
  logic                fault_r, fault_nxt;
  logic [DW-1:0]       heads_r [ORDER_COUNT];
  logic [PAGE_W-1:0]   res_start_r, res_start_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r;
  logic [PAGE_W-1:0]   out_start_r;
  status_t             out_status_r;

  // Head table access, one read and one write per cycle
  logic [OIW-1:0]      head_ra, head_wa;
  logic                head_we;
  logic [DW-1:0]       head_wd, head_rd;

  // Descriptor RAM: {block start, link}
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_wa, ram_ra;
  logic [MW-1:0]       ram_wd, ram_rd;
  logic [PAGE_W-1:0]   rd_start;
  logic [DW-1:0]       rd_link;

  // Helpers
  logic [BL_W-1:0]     need_bl, piece_bl;
  logic [ORD_W-1:0]    piece_ord;
  logic [CNT_W:0]      tail_full;

  osa_ram #(.WIDTH(MW), .DEPTH(DESCRIPTOR_DEPTH)) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  assign rd_start = ram_rd[MW-1:DW];
  assign rd_link  = ram_rd[DW-1:0];
  assign head_rd  = heads_r[head_ra];

  // Needed order for an allocate: ceiling log2 of the count
  assign need_bl   = bit_len(in_page_count - CNT_W'(1));
  // Largest piece that fits the remaining run, capped at the top order
  assign piece_bl  = bit_len(cnt_r);
  assign piece_ord = (int'(piece_bl) - 1 > ORDER_COUNT - 1) ? ORD_W'(ORDER_COUNT - 1)
                                                            : ORD_W'(piece_bl - BL_W'(1));
  assign tail_full = ((CNT_W + 1)'(1) << ord_r) - {1'b0, req_cnt_r};

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_alloc_start = out_start_r;
  assign out_status      = out_status_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    alloc_nxt      = alloc_r;
    req_cnt_nxt    = req_cnt_r;
    cnt_nxt        = cnt_r;
    run_start_nxt  = run_start_r;
    ord_nxt        = ord_r;
    k_nxt          = k_r;
    blk_nxt        = blk_r;
    sd_nxt         = sd_r;
    pd_nxt         = pd_r;
    pstart_nxt     = pstart_r;
    pord_nxt       = pord_r;
    recycle_nxt    = recycle_r;
    unused_nxt     = unused_r;
    fault_nxt      = fault_r;
    res_start_nxt  = res_start_r;
    res_status_nxt = res_status_r;
    head_ra        = '0;
    head_wa        = '0;
    head_we        = 1'b0;
    head_wd        = '0;
    ram_we         = 1'b0;
    ram_wa         = '0;
    ram_wd         = '0;
    ram_re         = 1'b0;
    ram_ra         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          alloc_nxt     = (in_command == CMD_ALLOC);
          req_cnt_nxt   = in_page_count;
          cnt_nxt       = in_page_count;
          run_start_nxt = in_start_page;
          ord_nxt       = ORD_W'(need_bl);
          k_nxt         = ORD_W'(need_bl);
          res_start_nxt = '0;
          state_nxt     = S_DONE;
          if (fault_r) begin
            res_status_nxt = ST_DESC;
          end else if (in_command == CMD_FREE) begin
            state_nxt = S_RUN;
          end else if (in_page_count == '0) begin
            res_status_nxt = ST_ZERO;
          end else if (int'(need_bl) >= ORDER_COUNT) begin
            res_status_nxt = ST_OOM;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // Look for the lowest nonempty list at or above the needed order
      S_SCAN: begin
        head_ra = k_r[OIW-1:0];
        if (head_rd != NULL_D) begin
          state_nxt = (k_r == ord_r) ? S_POP_RD : S_SPL_RD;
        end else if (int'(k_r) >= ORDER_COUNT - 1) begin
          res_status_nxt = ST_OOM;
          state_nxt      = S_DONE;
        end else begin
          k_nxt = k_r + ORD_W'(1);
        end
      end

      // Split: pop the top block of order k
      S_SPL_RD: begin
        head_ra   = k_r[OIW-1:0];
        sd_nxt    = head_rd;
        ram_re    = 1'b1;
        ram_ra    = head_rd[AW-1:0];
        state_nxt = S_SPL_WT;
      end

      S_SPL_WT: begin
        head_we    = 1'b1;
        head_wa    = k_r[OIW-1:0];
        head_wd    = rd_link;
        blk_nxt    = rd_start;
        pstart_nxt = rd_start;
        pord_nxt   = k_r - ORD_W'(1);
        ret_nxt    = S_SPL_HI;
        state_nxt  = S_TAKE;
      end

      S_SPL_HI: begin
        pstart_nxt = blk_r + (PAGE_W'(1) << (k_r - ORD_W'(1)));
        pord_nxt   = k_r - ORD_W'(1);
        ret_nxt    = S_SPL_RC;
        state_nxt  = S_TAKE;
      end

      // Recycle the split block's descriptor
      S_SPL_RC: begin
        ram_we      = 1'b1;
        ram_wa      = sd_r[AW-1:0];
        ram_wd      = {PAGE_W'(0), recycle_r};
        recycle_nxt = sd_r;
        k_nxt       = k_r - ORD_W'(1);
        state_nxt   = (k_r - ORD_W'(1) > ord_r) ? S_SPL_RD : S_POP_RD;
      end

      // Pop the allocated block
      S_POP_RD: begin
        head_ra = ord_r[OIW-1:0];
        if (head_rd == NULL_D) begin
          res_status_nxt = ST_OOM;
          state_nxt      = S_DONE;
        end else begin
          sd_nxt    = head_rd;
          ram_re    = 1'b1;
          ram_ra    = head_rd[AW-1:0];
          state_nxt = S_POP_WT;
        end
      end

      S_POP_WT: begin
        head_we       = 1'b1;
        head_wa       = ord_r[OIW-1:0];
        head_wd       = rd_link;
        blk_nxt       = rd_start;
        cnt_nxt       = tail_full[CNT_W-1:0];
        run_start_nxt = rd_start + req_cnt_r[PAGE_W-1:0];
        state_nxt     = S_RUN;
      end

      // Break a run into power-of-two pieces, low end first
      S_RUN: begin
        if (cnt_r == '0) begin
          if (alloc_r) begin
            state_nxt = S_FREC;
          end else begin
            res_status_nxt = ST_OK;
            state_nxt      = S_DONE;
          end
        end else begin
          pstart_nxt    = run_start_r;
          pord_nxt      = piece_ord;
          run_start_nxt = run_start_r + (PAGE_W'(1) << piece_ord);
          cnt_nxt       = cnt_r - (CNT_W'(1) << piece_ord);
          ret_nxt       = S_RUN;
          state_nxt     = S_TAKE;
        end
      end

      S_FREC: begin
        ram_we         = 1'b1;
        ram_wa         = sd_r[AW-1:0];
        ram_wd         = {PAGE_W'(0), recycle_r};
        recycle_nxt    = sd_r;
        res_start_nxt  = blk_r;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end

      // Take a descriptor: recycle list first, then never-used entries
      S_TAKE: begin
        if (recycle_r != NULL_D) begin
          pd_nxt    = recycle_r;
          ram_re    = 1'b1;
          ram_ra    = recycle_r[AW-1:0];
          state_nxt = S_TAKEW;
        end else if (unused_r != NULL_D) begin
          pd_nxt     = unused_r;
          unused_nxt = unused_r + DW'(1);
          state_nxt  = S_PWR;
        end else begin
          fault_nxt      = 1'b1;
          res_start_nxt  = '0;
          res_status_nxt = ST_DESC;
          state_nxt      = S_DONE;
        end
      end

      S_TAKEW: begin
        recycle_nxt = rd_link;
        state_nxt   = S_PWR;
      end

      // Push the piece onto its order's list
      S_PWR: begin
        head_ra   = pord_r[OIW-1:0];
        ram_we    = 1'b1;
        ram_wa    = pd_r[AW-1:0];
        ram_wd    = {pstart_r, head_rd};
        head_we   = 1'b1;
        head_wa   = pord_r[OIW-1:0];
        head_wd   = pd_r;
        state_nxt = ret_r;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_RUN;
      recycle_r   <= NULL_D;
      unused_r    <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ORDER_COUNT; i++) heads_r[i] <= NULL_D;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      recycle_r <= recycle_nxt;
      unused_r  <= unused_nxt;
      fault_r   <= fault_nxt;
      if (head_we) heads_r[head_wa] <= head_wd;
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    alloc_r      <= alloc_nxt;
    req_cnt_r    <= req_cnt_nxt;
    cnt_r        <= cnt_nxt;
    run_start_r  <= run_start_nxt;
    ord_r        <= ord_nxt;
    k_r          <= k_nxt;
    blk_r        <= blk_nxt;
    sd_r         <= sd_nxt;
    pd_r         <= pd_nxt;
    pstart_r     <= pstart_nxt;
    pord_r       <= pord_nxt;
    res_start_r  <= res_start_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_start_r  <= res_start_r;
      out_status_r <= res_status_r;
    end
  end

endmodule

// File: rtl/osa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module osa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
